@@ sv/rripsd_pkg.sv @@
`timescale 1ns / 1ps

package rripsd_pkg;

  localparam int unsigned STREAM_COUNT_DEF  = 8;
  localparam int unsigned SELECTOR_BITS_DEF = 10;

  localparam int unsigned SET_INDEX_W = 10;
  localparam int unsigned STREAM_ID_W = 3;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned THRESH_W    = 9;
  localparam int unsigned CNT_W       = 8;

  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic POL_SRRIP = 1'b0;
  localparam logic POL_BRRIP = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SRRIP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BRRIP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DRRIP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STREAM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FOLLOW = 3'd4;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd32;
  localparam logic [CNT_W-1:0]    CNT_MAX      = 8'hff;

  typedef struct packed {
    logic                   opcode;
    logic [SET_INDEX_W-1:0] set_index;
    logic [STREAM_ID_W-1:0] stream_id;
    logic                   speedup_stream;
  } evt_t;

  typedef struct packed {
    logic              chosen_policy;
    logic              long_fill;
    logic [KIND_W-1:0] set_kind;
  } res_t;

  function automatic logic [KIND_W-1:0] classify(input logic [SET_INDEX_W-1:0] idx);
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] nb;
    logic [3:0] m;
    a  = idx[2:0];
    b  = idx[9:7];
    m  = idx[6:3];
    nb = ~b;
    if (a == b && m == 4'h0) begin
      return KIND_SRRIP;
    end else if (a == nb && m == 4'h0) begin
      return KIND_BRRIP;
    end else if (a == b && m == 4'h1) begin
      return KIND_STREAM;
    end else if (a == nb && m == 4'h1) begin
      return KIND_DRRIP;
    end else begin
      return KIND_FOLLOW;
    end
  endfunction

endpackage

@@ sv/rripsd_if.sv @@
`timescale 1ns / 1ps

interface rripsd_evt_if import rripsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [SET_INDEX_W-1:0] set_index;
  logic [STREAM_ID_W-1:0] stream_id;
  logic                   speedup_stream;

  modport source (output valid, opcode, set_index, stream_id, speedup_stream,
                  input ready);
  modport sink (input valid, opcode, set_index, stream_id, speedup_stream,
                output ready);
endinterface

interface rripsd_res_if import rripsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chosen_policy;
  logic              long_fill;
  logic [KIND_W-1:0] set_kind;

  modport source (output valid, chosen_policy, long_fill, set_kind, input ready);
  modport sink (input valid, chosen_policy, long_fill, set_kind, output ready);
endinterface

interface rripsd_cfg_if import rripsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [THRESH_W-1:0] bimodal_threshold;

  modport source (output valid, bimodal_threshold, input ready);
  modport sink (input valid, bimodal_threshold, output ready);
endinterface

@@ sv/rripsd_core.sv @@
`timescale 1ns / 1ps

module rripsd_core import rripsd_pkg::*; #(
  parameter int unsigned STREAM_COUNT  = STREAM_COUNT_DEF,
  parameter int unsigned SELECTOR_BITS = SELECTOR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  evt_t                item,
  input  logic [THRESH_W-1:0] threshold,
  output res_t                decision
);

  localparam int unsigned SID_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_ONE = {{(SELECTOR_BITS-1){1'b0}}, 1'b1};

  logic [SELECTOR_BITS-1:0] duel;
  logic [SELECTOR_BITS-1:0] mix;
  logic [SELECTOR_BITS-1:0] ssel [STREAM_COUNT];
  logic [CNT_W-1:0]         cnt;

  logic [SELECTOR_BITS-1:0] duel_next;
  logic [SELECTOR_BITS-1:0] mix_next;
  logic [SELECTOR_BITS-1:0] ssel_next;
  logic [CNT_W-1:0]         cnt_next;

  logic [KIND_W-1:0]        kind;
  logic [SID_W+STREAM_ID_W-1:0] sid_wide;
  logic [SID_W-1:0]         sid_idx;
  logic                     sid_ok;
  logic [SELECTOR_BITS-1:0] stream_val;
  logic                     duel_pol;
  logic                     stream_pol;
  logic                     pol;
  logic                     is_fill;
  logic [CNT_W:0]           cnt_inc;

  always_comb begin
    kind     = classify(item.set_index);
    is_fill  = (item.opcode == OP_FILL);
    sid_wide = {{SID_W{1'b0}}, item.stream_id};
    sid_idx  = sid_wide[SID_W-1:0];
    sid_ok   = (32'(item.stream_id) < STREAM_COUNT);
    stream_val = sid_ok ? ssel[sid_idx] : SEL_MID;

    if (kind == KIND_SRRIP) begin
      duel_pol = POL_SRRIP;
    end else if (kind == KIND_BRRIP) begin
      duel_pol = POL_BRRIP;
    end else begin
      duel_pol = (duel >= SEL_MID) ? POL_BRRIP : POL_SRRIP;
    end

    if (item.speedup_stream) begin
      stream_pol = (stream_val >= SEL_MID) ? POL_BRRIP : POL_SRRIP;
    end else begin
      stream_pol = duel_pol;
    end

    if (is_fill && (kind == KIND_STREAM || (kind == KIND_FOLLOW && mix > SEL_MID))) begin
      pol = stream_pol;
    end else begin
      pol = duel_pol;
    end

    decision.chosen_policy = pol;
    decision.long_fill     = is_fill && (pol == POL_SRRIP || cnt == '0);
    decision.set_kind      = kind;

    duel_next = duel;
    mix_next  = mix;
    ssel_next = stream_val;
    case (kind)
      KIND_SRRIP: begin
        if (duel != SEL_MAX) duel_next = duel + SEL_ONE;
        if (stream_val != SEL_MAX) ssel_next = stream_val + SEL_ONE;
      end
      KIND_BRRIP: begin
        if (duel != '0) duel_next = duel - SEL_ONE;
        if (stream_val != '0) ssel_next = stream_val - SEL_ONE;
      end
      KIND_DRRIP: begin
        if (mix != SEL_MAX) mix_next = mix + SEL_ONE;
      end
      KIND_STREAM: begin
        if (mix != '0) mix_next = mix - SEL_ONE;
      end
      default: begin
      end
    endcase

    cnt_inc = {1'b0, cnt} + 9'd1;
    if (cnt_inc < threshold) begin
      cnt_next = (cnt == CNT_MAX) ? cnt : cnt_inc[CNT_W-1:0];
    end else begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duel <= SEL_MID;
      mix  <= SEL_MID;
      cnt  <= '0;
      for (int i = 0; i < STREAM_COUNT; i++) begin
        ssel[i] <= SEL_MID;
      end
    end else if (fire && is_fill) begin
      duel <= duel_next;
      mix  <= mix_next;
      cnt  <= cnt_next;
      if (sid_ok && (kind == KIND_SRRIP || kind == KIND_BRRIP)) begin
        ssel[sid_idx] <= ssel_next;
      end
    end
  end

endmodule

@@ sv/rrip_set_dueling_selector.sv @@
`timescale 1ns / 1ps

// channel  role       payload
// evt      sink       opcode, set_index, stream_id, speedup_stream
// res      source     chosen_policy, long_fill, set_kind
// cfg      sink       bimodal_threshold (always ready)
//
// one event per cycle sustained while res is taken; res valid follows the evt transfer
// through the input register, then selector update and decision into the result register
// rst is synchronous: selectors to midpoint, access counter to 0, threshold to 32
// a stalled res holds the result register; the input register then fills and
// evt.ready drops until res is taken

module rrip_set_dueling_selector import rripsd_pkg::*; #(
  parameter int unsigned STREAM_COUNT  = STREAM_COUNT_DEF,
  parameter int unsigned SELECTOR_BITS = SELECTOR_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  rripsd_evt_if.sink   evt,
  rripsd_res_if.source res,
  rripsd_cfg_if.sink   cfg
);

  logic                hold_valid;
  evt_t                hold;
  logic                res_valid;
  res_t                res_data;
  logic [THRESH_W-1:0] threshold;
  logic                advance;
  res_t                decision;

  assign advance   = hold_valid && (!res_valid || res.ready);
  assign evt.ready = !hold_valid || advance;
  assign cfg.ready = 1'b1;

  assign res.valid         = res_valid;
  assign res.chosen_policy = res_data.chosen_policy;
  assign res.long_fill     = res_data.long_fill;
  assign res.set_kind      = res_data.set_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.bimodal_threshold;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      hold.opcode         <= evt.opcode;
      hold.set_index      <= evt.set_index;
      hold.stream_id      <= evt.stream_id;
      hold.speedup_stream <= evt.speedup_stream;
    end
  end

  rripsd_core #(
    .STREAM_COUNT  (STREAM_COUNT),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (hold),
    .threshold (threshold),
    .decision  (decision)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= decision;
    end
  end

endmodule

@@ sim/tb_rrip_set_dueling_selector.sv @@
`timescale 1ns / 1ps

module tb_rrip_set_dueling_selector;
  import rripsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned CHUNKS       = 13;
  localparam int unsigned CHUNK_EVENTS = 140;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [SELECTOR_BITS_DEF-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS_DEF-1){1'b0}}};
  localparam logic [SELECTOR_BITS_DEF-1:0] SEL_MAX = '1;

  typedef logic [SELECTOR_BITS_DEF-1:0] sel_t;

  typedef struct packed {
    evt_t ev;
    logic typed;
    res_t want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rripsd_evt_if evt_bus ();
  rripsd_res_if res_bus ();
  rripsd_cfg_if cfg_bus ();

  rrip_set_dueling_selector uut (
    .clk (clk),
    .rst (rst),
    .evt (evt_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [THRESH_W-1:0] threshold = THRESH_RESET;
  sel_t                duel_sel  = SEL_MID;
  sel_t                mix_sel   = SEL_MID;
  sel_t                stream_sel [STREAM_COUNT_DEF];
  logic [CNT_W-1:0]    bim_count = '0;

  res_t        pending_decisions [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady_flow    = 1'b0;

  const dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{OP_LOOKUP, 10'h000, 3'd0, 1'b0}, 1'b1, '{POL_SRRIP, 1'b0, KIND_SRRIP}},
    '{'{OP_LOOKUP, 10'h007, 3'd0, 1'b0}, 1'b1, '{POL_BRRIP, 1'b0, KIND_BRRIP}},
    '{'{OP_LOOKUP, 10'h00f, 3'd3, 1'b0}, 1'b1, '{POL_BRRIP, 1'b0, KIND_DRRIP}},
    '{'{OP_LOOKUP, 10'h008, 3'd5, 1'b1}, 1'b1, '{POL_BRRIP, 1'b0, KIND_STREAM}},
    '{'{OP_LOOKUP, 10'h3ff, 3'd7, 1'b1}, 1'b1, '{POL_BRRIP, 1'b0, KIND_FOLLOW}},
    '{'{OP_FILL,   10'h387, 3'd7, 1'b1}, 1'b1, '{POL_SRRIP, 1'b1, KIND_SRRIP}},
    '{'{OP_FILL,   10'h380, 3'd0, 1'b0}, 1'b0, '0},
    '{'{OP_FILL,   10'h00f, 3'd2, 1'b0}, 1'b0, '0},
    '{'{OP_FILL,   10'h3ff, 3'd0, 1'b1}, 1'b0, '0},
    '{'{OP_FILL,   10'h010, 3'd0, 1'b0}, 1'b0, '0},
    '{'{OP_FILL,   10'h38f, 3'd7, 1'b1}, 1'b0, '0},
    '{'{OP_FILL,   10'h008, 3'd0, 1'b1}, 1'b0, '0},
    '{'{OP_FILL,   10'h3ff, 3'd0, 1'b1}, 1'b0, '0},
    '{'{OP_LOOKUP, 10'h388, 3'd4, 1'b1}, 1'b0, '0},
    '{'{OP_FILL,   10'h000, 3'd6, 1'b0}, 1'b0, '0},
    '{'{OP_FILL,   10'h2aa, 3'd3, 1'b1}, 1'b0, '0},
    '{'{OP_LOOKUP, 10'h155, 3'd1, 1'b0}, 1'b0, '0},
    '{'{OP_FILL,   10'h388, 3'd7, 1'b1}, 1'b0, '0}
  };

  const logic [THRESH_W-1:0] chunk_thresholds [CHUNKS] = '{
    9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd257, 9'd255,
    9'd3, 9'd32, 9'd5, 9'd128, 9'd17, 9'd256
  };

  initial begin
    for (int i = 0; i < STREAM_COUNT_DEF; i++) begin
      stream_sel[i] = SEL_MID;
    end
  end

  function automatic logic [KIND_W-1:0] kind_of_set(input logic [SET_INDEX_W-1:0] idx);
    logic same;
    logic mirrored;
    same     = idx[2:0] == idx[9:7];
    mirrored = idx[2:0] == ~idx[9:7];
    case (idx[6:3])
      4'd0: begin
        if (same) return KIND_SRRIP;
        if (mirrored) return KIND_BRRIP;
      end
      4'd1: begin
        if (same) return KIND_STREAM;
        if (mirrored) return KIND_DRRIP;
      end
      default: ;
    endcase
    return KIND_FOLLOW;
  endfunction

  function automatic sel_t sel_up(input sel_t s);
    return (s == SEL_MAX) ? s : s + 1'b1;
  endfunction

  function automatic sel_t sel_down(input sel_t s);
    return (s == '0) ? s : s - 1'b1;
  endfunction

  function automatic logic duel_policy(input logic [KIND_W-1:0] k);
    if (k == KIND_SRRIP) return POL_SRRIP;
    if (k == KIND_BRRIP) return POL_BRRIP;
    return (duel_sel < SEL_MID) ? POL_SRRIP : POL_BRRIP;
  endfunction

  function automatic res_t drrip_decide(input evt_t e);
    res_t r;
    logic [KIND_W-1:0] k;
    logic per_stream;
    k = kind_of_set(e.set_index);
    r.set_kind = k;
    r.long_fill = 1'b0;
    if (e.opcode == OP_LOOKUP) begin
      r.chosen_policy = duel_policy(k);
    end else begin
      case (k)
        KIND_SRRIP: begin
          duel_sel = sel_up(duel_sel);
          stream_sel[e.stream_id] = sel_up(stream_sel[e.stream_id]);
        end
        KIND_BRRIP: begin
          duel_sel = sel_down(duel_sel);
          stream_sel[e.stream_id] = sel_down(stream_sel[e.stream_id]);
        end
        KIND_DRRIP: mix_sel = sel_up(mix_sel);
        KIND_STREAM: mix_sel = sel_down(mix_sel);
        default: ;
      endcase
      per_stream = (k == KIND_STREAM) || (k == KIND_FOLLOW && mix_sel > SEL_MID);
      if (per_stream && e.speedup_stream) begin
        r.chosen_policy = (stream_sel[e.stream_id] < SEL_MID) ? POL_SRRIP : POL_BRRIP;
      end else begin
        r.chosen_policy = duel_policy(k);
      end
      r.long_fill = (r.chosen_policy == POL_SRRIP) || (bim_count == '0);
      if (int'(bim_count) + 1 < int'(threshold)) begin
        if (bim_count != CNT_MAX) bim_count = bim_count + 1'b1;
      end else begin
        bim_count = '0;
      end
    end
    return r;
  endfunction

  function automatic logic [SET_INDEX_W-1:0] pick_set(input logic [KIND_W-1:0] k);
    logic [2:0] tag_bits;
    tag_bits = 3'($urandom_range(7));
    case (k)
      KIND_SRRIP: return {tag_bits, 4'd0, tag_bits};
      KIND_BRRIP: return {tag_bits, 4'd0, ~tag_bits};
      KIND_STREAM: return {tag_bits, 4'd1, tag_bits};
      KIND_DRRIP: return {tag_bits, 4'd1, ~tag_bits};
      default: return SET_INDEX_W'($urandom_range(1023));
    endcase
  endfunction

  // leaning chunks fill mostly one set kind, pushing its selectors hard toward saturation
  function automatic evt_t random_event(input logic leaning, input logic [KIND_W-1:0] lean_kind,
                                        input logic [STREAM_ID_W-1:0] lean_stream);
    evt_t e;
    e.speedup_stream = 1'($urandom_range(1));
    if (leaning && $urandom_range(99) < 96) begin
      e.opcode    = OP_FILL;
      e.set_index = pick_set(lean_kind);
      e.stream_id = (lean_kind == KIND_DRRIP) ? STREAM_ID_W'($urandom_range(7)) : lean_stream;
    end else begin
      e.opcode    = 1'($urandom_range(1));
      e.set_index = ($urandom_range(1) == 0) ? pick_set(KIND_W'($urandom_range(4)))
                                             : SET_INDEX_W'($urandom_range(1023));
      e.stream_id = STREAM_ID_W'($urandom_range(7));
    end
    return e;
  endfunction

  task automatic send_event(input evt_t e, input logic typed, input res_t want);
    res_t predicted;
    while (!steady_flow && $urandom_range(99) < 24) begin
      evt_bus.valid <= 1'b0;
      @(negedge clk);
    end
    evt_bus.valid          <= 1'b1;
    evt_bus.opcode         <= e.opcode;
    evt_bus.set_index      <= e.set_index;
    evt_bus.stream_id      <= e.stream_id;
    evt_bus.speedup_stream <= e.speedup_stream;
    @(posedge clk);
    while (!evt_bus.ready) @(posedge clk);
    predicted = drrip_decide(e);
    pending_decisions.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    evt_bus.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid             <= 1'b1;
    cfg_bus.bimodal_threshold <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    threshold = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    evt_bus.valid          = 1'b0;
    evt_bus.opcode         = OP_FILL;
    evt_bus.set_index      = '0;
    evt_bus.stream_id      = '0;
    evt_bus.speedup_stream = 1'b0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.bimodal_threshold = THRESH_RESET;
  end

  always @(negedge clk) begin
    res_bus.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // result check
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_decisions.pop_front();
        if (res_bus.chosen_policy !== want.chosen_policy) begin
          $error("chosen_policy: expected %0d, got %0d", want.chosen_policy,
                 res_bus.chosen_policy);
          mismatch_count++;
        end
        if (res_bus.long_fill !== want.long_fill) begin
          $error("long_fill: expected %0d, got %0d", want.long_fill, res_bus.long_fill);
          mismatch_count++;
        end
        if (res_bus.set_kind !== want.set_kind) begin
          $error("set_kind: expected %0d, got %0d", want.set_kind, res_bus.set_kind);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rrip_set_dueling_selector test failed");
      $finish;
    end
  end

  initial begin
    logic [THRESH_W-1:0] thr;
    logic                leaning;
    logic [KIND_W-1:0]   lean_kind;
    logic [STREAM_ID_W-1:0] lean_stream;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int c = 0; c < CHUNKS; c++) begin
      thr = (c == 8) ? THRESH_W'($urandom_range(1, 256)) : chunk_thresholds[c];
      write_threshold(thr);
      steady_flow = (c == 5 || c == 6);
      leaning     = (c < 12);
      case (c / 4)
        0: begin
          lean_kind   = KIND_SRRIP;
          lean_stream = 3'd0;
        end
        1: begin
          lean_kind   = KIND_DRRIP;
          lean_stream = 3'd0;
        end
        default: begin
          lean_kind   = KIND_BRRIP;
          lean_stream = 3'd1;
        end
      endcase
      for (int n = 0; n < CHUNK_EVENTS; n++) begin
        send_event(random_event(leaning, lean_kind, lean_stream), 1'b0, '0);
      end
    end
    evt_bus.valid <= 1'b0;

    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_decisions.size() == 0) begin
      $display("rrip_set_dueling_selector test passed");
    end else begin
      $display("rrip_set_dueling_selector test failed");
    end
    $finish;
  end

endmodule
